### design/uasp_pkg.sv
package uasp_pkg;

   // Fixed-point constants (signed Q9.16)
   localparam int VAL_W      = 24;
   localparam int ACC_W      = 26;
   localparam int IDX_W      = 4;
   localparam int CNT_W      = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int DEF_MAX_STEPS    = 128;
   localparam int DEF_NUM_JOINTS   = 6;
   localparam int DEF_CORDIC_ITERS = 16;

   localparam logic signed [ACC_W-1:0] Q_PI        = 26'sd205887;
   localparam logic signed [ACC_W-1:0] Q_HALF_PI   = 26'sd102944;
   localparam logic signed [ACC_W-1:0] Q_TWO_PI    = 26'sd411775;
   localparam logic signed [ACC_W-1:0] CORDIC_GAIN = 26'sd39797;
   localparam logic signed [ACC_W-1:0] V_MAX       = 26'sd8388607;
   localparam logic signed [ACC_W-1:0] V_MIN       = -26'sd8388608;

   // Input modes
   localparam logic [MODE_W-1:0] MODE_LOAD_STATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_CTRL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUN        = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_LOW       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_HIGH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOW       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_HIGH      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_JOINT_LIMIT = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [IDX_W-1:0]        elem_index;
      logic signed [VAL_W-1:0] elem_value;
      logic [CNT_W-1:0]        step_count;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_index;
      logic signed [VAL_W-1:0] out_value;
      logic                    in_bounds;
      logic [CNT_W-1:0]        steps_done;
      logic                    last;
   } rsp_type;

   // Arctangent table, Q16, zero from iteration 17 on
   function automatic logic signed [ACC_W-1:0] atan_q(input logic [4:0] i);
      logic signed [ACC_W-1:0] r;
      case (i)
         5'd0:  r = 26'sd51472;
         5'd1:  r = 26'sd30386;
         5'd2:  r = 26'sd16055;
         5'd3:  r = 26'sd8150;
         5'd4:  r = 26'sd4091;
         5'd5:  r = 26'sd2047;
         5'd6:  r = 26'sd1024;
         5'd7:  r = 26'sd512;
         5'd8:  r = 26'sd256;
         5'd9:  r = 26'sd128;
         5'd10: r = 26'sd64;
         5'd11: r = 26'sd32;
         5'd12: r = 26'sd16;
         5'd13: r = 26'sd8;
         5'd14: r = 26'sd4;
         5'd15: r = 26'sd2;
         5'd16: r = 26'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Saturate to the 24 bit signed range
   function automatic logic signed [VAL_W-1:0] sat24(input logic signed [ACC_W+1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > 28'sd8388607) r = 24'sh7FFFFF;
      else if (v < -28'sd8388608) r = 24'sh800000;
      else r = v[VAL_W-1:0];
      return r;
   endfunction

endpackage

### design/unicycle_arm_state_propagator_unit.sv
// Euler propagator for a unicycle base with an arm. Load items (mode 0 state,
// mode 1 control) give no result. A run item integrates step_count steps
// (clamped to MAX_STEPS) from the stored state, stopping early after a step
// that leaves the bounds. Each step updates the joints, the distance, sin
// and cos, x and y and the heading, then checks the bounds, using a single
// shared 26x26 multiplier and an iterative CORDIC for sin and cos.
// The run then emits 3+NUM_JOINTS results on rsp_valid in consecutive
// cycles, one cycle each; the receiver cannot stall them, so it must take
// every strobe. busy is high from the accepted run item until the last
// result is on the ports.
module unicycle_arm_state_propagator_unit
   import uasp_pkg::*;
#(
   parameter int MAX_STEPS    = DEF_MAX_STEPS,
   parameter int NUM_JOINTS   = DEF_NUM_JOINTS,
   parameter int CORDIC_ITERS = DEF_CORDIC_ITERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NSTATE  = 3 + NUM_JOINTS;
   localparam int NCTRL   = 2 + NUM_JOINTS;
   localparam int SCNT_W  = $clog2(MAX_STEPS + 1);
   localparam int SIDX_W  = $clog2(NSTATE);
   localparam int CIDX_W  = $clog2(NCTRL);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_JOINT = 8'b00000010,
      ST_SPEED = 8'b00000100,
      ST_TRIG  = 8'b00001000,
      ST_XY    = 8'b00010000,
      ST_HEAD  = 8'b00100000,
      ST_CHECK = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   // configuration registers
   logic [15:0]             time_step_ff;
   logic signed [VAL_W-1:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [22:0]             joint_limit_ff;

   // stored vectors and working vector
   logic signed [VAL_W-1:0] pose_mem [NSTATE];
   logic signed [VAL_W-1:0] ctrl_mem [NCTRL];
   logic signed [VAL_W-1:0] v_ff [NSTATE];

   state_type               state_ff;
   logic [SCNT_W-1:0]       want_ff, done_ff;
   logic [SIDX_W-1:0]       k_ff;
   logic                    ok_ff;
   logic                    sub_ff;
   logic signed [VAL_W-1:0] d_ff;
   logic signed [ACC_W-1:0] sin_ff, cos_ff;

   // shared multiplier with a registered product
   logic signed [ACC_W-1:0]   mul_a, mul_b;
   logic signed [2*ACC_W-1:0] prod_ff;
   logic signed [ACC_W+1:0]   rnd;

   logic                    cdc_start, cdc_done;
   logic signed [ACC_W-1:0] cdc_sin, cdc_cos;

   logic                    accept;
   logic [SCNT_W-1:0]       want_clamped;
   logic                    viol;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign want_clamped = (int'(req_data.step_count) > MAX_STEPS) ?
                         SCNT_W'(MAX_STEPS) : SCNT_W'(req_data.step_count);

   // rounded product of the previous cycle, (p + 2^15) >> 16
   assign rnd = 28'((prod_ff + 52'sd32768) >>> 16);

   // multiplier operand select
   always_comb begin
      mul_a = ACC_W'($signed({1'b0, time_step_ff}));
      mul_b = '0;
      case (state_ff)
         ST_JOINT: mul_b = ACC_W'(ctrl_mem[CIDX_W'(k_ff) + CIDX_W'(2)]);
         ST_SPEED: mul_b = ACC_W'(ctrl_mem[1]);
         ST_XY: begin
            mul_a = ACC_W'(d_ff);
            mul_b = sub_ff ? sin_ff : cos_ff;
         end
         ST_HEAD:  mul_b = ACC_W'(ctrl_mem[0]);
         default:  mul_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // bounds check over the working vector
   always_comb begin
      viol = 1'b0;
      if (v_ff[0] < x_low_ff || v_ff[0] > x_high_ff) viol = 1'b1;
      if (v_ff[1] < y_low_ff || v_ff[1] > y_high_ff) viol = 1'b1;
      if (ACC_W'(v_ff[2]) < -Q_PI || ACC_W'(v_ff[2]) > Q_PI) viol = 1'b1;
      for (int j = 0; j < NUM_JOINTS; j++) begin
         if (ACC_W'(v_ff[3+j]) < -ACC_W'($signed({1'b0, joint_limit_ff})) ||
             ACC_W'(v_ff[3+j]) >  ACC_W'($signed({1'b0, joint_limit_ff})))
            viol = 1'b1;
      end
   end

   assign cdc_start = (state_ff == ST_SPEED) && sub_ff;

   uasp_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cdc_start),
      .angle   (v_ff[2]),
      .done    (cdc_done),
      .sin_out (cdc_sin),
      .cos_out (cdc_cos)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= 16'd655;
         x_low_ff       <= -24'sd5898240;
         x_high_ff      <= 24'sd6553600;
         y_low_ff       <= -24'sd6553600;
         y_high_ff      <= 24'sd5898240;
         joint_limit_ff <= 23'd3932160;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEP:   time_step_ff   <= csr_wdata[15:0];
            CSR_X_LOW:       x_low_ff       <= csr_wdata;
            CSR_X_HIGH:      x_high_ff      <= csr_wdata;
            CSR_Y_LOW:       y_low_ff       <= csr_wdata;
            CSR_Y_HIGH:      y_high_ff      <= csr_wdata;
            CSR_JOINT_LIMIT: joint_limit_ff <= csr_wdata[22:0];
            default: ;
         endcase
      end
   end

   // loads into the stored vectors
   always_ff @(posedge clock) begin
      if (accept && req_data.mode == MODE_LOAD_STATE && req_data.elem_index < IDX_W'(NSTATE))
         pose_mem[SIDX_W'(req_data.elem_index)] <= req_data.elem_value;
      if (accept && req_data.mode == MODE_LOAD_CTRL && req_data.elem_index < IDX_W'(NCTRL))
         ctrl_mem[CIDX_W'(req_data.elem_index)] <= req_data.elem_value;
   end

   // sequencer; sub_ff marks the multiply-issue (0) and write-back (1) half
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_data.mode == MODE_RUN) begin
                  for (int k = 0; k < NSTATE; k++) v_ff[k] <= pose_mem[k];
                  want_ff  <= want_clamped;
                  done_ff  <= '0;
                  ok_ff    <= 1'b1;
                  k_ff     <= '0;
                  sub_ff   <= 1'b0;
                  state_ff <= (want_clamped == '0) ? ST_OUT : ST_JOINT;
               end
            end
            ST_JOINT: begin
               sub_ff <= !sub_ff;
               if (sub_ff) begin
                  v_ff[SIDX_W'(k_ff) + SIDX_W'(3)] <=
                     sat24(28'(v_ff[SIDX_W'(k_ff) + SIDX_W'(3)]) + rnd);
                  if (k_ff == SIDX_W'(NUM_JOINTS - 1)) begin
                     k_ff     <= '0;
                     state_ff <= ST_SPEED;
                  end else begin
                     k_ff <= k_ff + SIDX_W'(1);
                  end
               end
            end
            ST_SPEED: begin
               sub_ff <= !sub_ff;
               if (sub_ff) begin
                  d_ff     <= sat24(rnd);
                  state_ff <= ST_TRIG;
               end
            end
            ST_TRIG: begin
               if (cdc_done) begin
                  sin_ff   <= cdc_sin;
                  cos_ff   <= cdc_cos;
                  k_ff     <= '0;
                  state_ff <= ST_XY;
               end
            end
            ST_XY: begin
               // k_ff 0 issues cos, 1 writes x and issues sin, 2 writes y
               sub_ff <= (k_ff == SIDX_W'(0));
               if (k_ff == SIDX_W'(1)) v_ff[0] <= sat24(28'(v_ff[0]) + rnd);
               if (k_ff == SIDX_W'(2)) begin
                  v_ff[1]  <= sat24(28'(v_ff[1]) + rnd);
                  k_ff     <= '0;
                  sub_ff   <= 1'b0;
                  state_ff <= ST_HEAD;
               end else begin
                  k_ff <= k_ff + SIDX_W'(1);
               end
            end
            ST_HEAD: begin
               sub_ff <= !sub_ff;
               if (sub_ff) begin
                  v_ff[2]  <= sat24(28'(v_ff[2]) + rnd);
                  done_ff  <= done_ff + SCNT_W'(1);
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               sub_ff <= 1'b0;
               if (viol) begin
                  ok_ff    <= 1'b0;
                  state_ff <= ST_OUT;
               end else if (done_ff == want_ff) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_JOINT;
               end
            end
            ST_OUT: begin
               rsp_valid           <= 1'b1;
               rsp_data.out_index  <= IDX_W'(k_ff);
               rsp_data.out_value  <= v_ff[k_ff];
               rsp_data.in_bounds  <= ok_ff;
               rsp_data.steps_done <= CNT_W'(done_ff);
               rsp_data.last       <= (k_ff == SIDX_W'(NSTATE - 1));
               if (k_ff == SIDX_W'(NSTATE - 1)) begin
                  k_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff <= k_ff + SIDX_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // results only come while a run is reporting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_OUT))
      else $error("result outside report phase");
   // the last result returns the block to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (state_ff == ST_IDLE))
      else $error("last result without idle");
   // step count never passes the request
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (done_ff <= want_ff))
      else $error("steps overrun");
   // cordic only finishes while waiting on it
   assert property (@(posedge clock) disable iff (reset)
      cdc_done |-> (state_ff == ST_TRIG))
      else $error("unexpected cordic done");

endmodule

### design/uasp_cordic.sv
// Iterative CORDIC rotation: one iteration per cycle on a shared add/shift stage.
module uasp_cordic
   import uasp_pkg::*;
#(
   parameter int CORDIC_ITERS = DEF_CORDIC_ITERS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VAL_W-1:0] angle,
   output logic                    done,
   output logic signed [ACC_W-1:0] sin_out,
   output logic signed [ACC_W-1:0] cos_out
);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_RED  = 3'b010,
      CS_ROT  = 3'b100
   } cstate_type;

   cstate_type              state_ff, state_in;
   logic [4:0]              iter_ff, iter_in;
   logic signed [ACC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                    neg_ff, neg_in;
   logic                    done_ff, done_in;

   // Range reduction of a 24 bit heading: one 2*pi step per cycle
   logic signed [ACC_W-1:0] xs, ys;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      xs       = x_ff >>> iter_ff;
      ys       = y_ff >>> iter_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               z_in     = ACC_W'(angle);
               state_in = CS_RED;
            end
         end
         CS_RED: begin
            // step into (-pi, pi] then fold into [-pi/2, pi/2]
            if (z_ff > Q_PI) begin
               z_in = z_ff - Q_TWO_PI;
            end else if (z_ff <= -Q_PI) begin
               z_in = z_ff + Q_TWO_PI;
            end else begin
               neg_in = 1'b0;
               if (z_ff > Q_HALF_PI) begin
                  z_in   = z_ff - Q_PI;
                  neg_in = 1'b1;
               end else if (z_ff < -Q_HALF_PI) begin
                  z_in   = z_ff + Q_PI;
                  neg_in = 1'b1;
               end
               x_in     = CORDIC_GAIN;
               y_in     = '0;
               iter_in  = '0;
               state_in = CS_ROT;
            end
         end
         CS_ROT: begin
            if (!z_ff[ACC_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_q(iter_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_q(iter_ff);
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(CORDIC_ITERS - 1)) begin
               done_in  = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
   end

   assign done    = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

   // done is a single-cycle pulse
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("cordic done held");
   // rotation finishes through the last iteration only
   assert property (@(posedge clock) disable iff (reset)
      done_in |-> (state_ff == CS_ROT))
      else $error("cordic done outside rotation");
   // reduction always moves on toward rotation
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_RED) |=> (state_ff != CS_IDLE))
      else $error("cordic reduce sequence");

endmodule

### verif/unicycle_arm_state_propagator_unit_tb.sv
`timescale 1ns / 100ps

module unicycle_arm_state_propagator_unit_tb;
   import uasp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int  N_STATE     = 3 + DEF_NUM_JOINTS;
   localparam int  N_CTRL      = 2 + DEF_NUM_JOINTS;
   localparam int  DRAIN_WAIT  = 40;
   localparam longint CYCLE_LIMIT = 20000000;
   localparam int  RANDOM_ITEMS = 385;

   logic clock, reset, start, busy, rsp_valid, csr_we;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   unicycle_arm_state_propagator_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Mirror of the block's registers and stored vectors
   longint pose_mirror [N_STATE];
   longint ctrl_mirror [N_CTRL];
   longint dt_reg, x_lo, x_hi, y_lo, y_hi, joint_lim;

   rsp_type expected_results[$];
   int     error_count = 0;
   int     items_sent  = 0;
   int     runs_sent   = 0;
   int     results_seen = 0;
   int     early_stops = 0;
   bit     no_idle = 0;
   longint cycle_count = 0;

   // Clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic longint sat_value(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // Q16 product, round to nearest, ties up
   function automatic longint qmul(input longint a, input longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   function automatic void heading_sin_cos(input longint h, output longint s,
                                           output longint c);
      longint at_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};
      longint r, x, y, nx;
      longint two_pi, pi, half_pi;
      bit neg;
      two_pi  = Q_TWO_PI;
      pi      = Q_PI;
      half_pi = Q_HALF_PI;
      neg = 0;
      r = h % two_pi;
      if (r < 0) r += two_pi;
      if (r > pi) r -= two_pi;
      // fold into the right half plane
      if (r > half_pi) begin
         r -= pi;
         neg = 1;
      end else if (r < -half_pi) begin
         r += pi;
         neg = 1;
      end
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < DEF_CORDIC_ITERS; i++) begin
         if (r >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            r -= at_tab[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            r += at_tab[i];
         end
         x = nx;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic bit pose_in_bounds(input longint v [N_STATE]);
      if (v[0] < x_lo || v[0] > x_hi) return 0;
      if (v[1] < y_lo || v[1] > y_hi) return 0;
      if (v[2] < -64'sd205887 || v[2] > 64'sd205887) return 0;
      for (int j = 0; j < DEF_NUM_JOINTS; j++)
         if (v[3+j] < -joint_lim || v[3+j] > joint_lim) return 0;
      return 1;
   endfunction

   // Euler propagation of an accepted item; queues the results it causes
   function automatic void propagate_item(input req_type r);
      longint v [N_STATE];
      longint s, c, d, val;
      int n, done;
      bit ok;
      rsp_type e;
      val = longint'(r.elem_value);
      if (r.mode == MODE_LOAD_STATE) begin
         if (r.elem_index < N_STATE) pose_mirror[r.elem_index] = val;
         return;
      end
      if (r.mode == MODE_LOAD_CTRL) begin
         if (r.elem_index < N_CTRL) ctrl_mirror[r.elem_index] = val;
         return;
      end
      if (r.mode != MODE_RUN) return;
      n = (r.step_count > DEF_MAX_STEPS) ? DEF_MAX_STEPS : r.step_count;
      for (int k = 0; k < N_STATE; k++) v[k] = sat_value(pose_mirror[k]);
      done = 0;
      ok = 1;
      while (done < n) begin
         for (int j = 0; j < DEF_NUM_JOINTS; j++)
            v[3+j] = sat_value(v[3+j] + qmul(dt_reg, ctrl_mirror[2+j]));
         heading_sin_cos(v[2], s, c);
         d = sat_value(qmul(dt_reg, ctrl_mirror[1]));
         v[0] = sat_value(v[0] + qmul(d, c));
         v[1] = sat_value(v[1] + qmul(d, s));
         v[2] = sat_value(v[2] + qmul(dt_reg, ctrl_mirror[0]));
         done++;
         if (!pose_in_bounds(v)) begin
            ok = 0;
            break;
         end
      end
      for (int k = 0; k < N_STATE; k++) begin
         e.out_index  = IDX_W'(k);
         e.out_value  = v[k][VAL_W-1:0];
         e.in_bounds  = ok;
         e.steps_done = CNT_W'(done);
         e.last       = (k == N_STATE - 1);
         expected_results.insert(expected_results.size(), e);
      end
      runs_sent++;
      if (!ok) early_stops++;
   endfunction

   // Result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_data.out_index !== e.out_index || rsp_data.out_value !== e.out_value ||
                rsp_data.in_bounds !== e.in_bounds ||
                rsp_data.steps_done !== e.steps_done || rsp_data.last !== e.last) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               error_count++;
            end
         end
      end
   end

   // One transfer on the command port; called and returns at a falling edge
   task automatic send_item(input logic [MODE_W-1:0] mode, input int idx,
                            input longint val, input int cnt);
      int gap;
      bit taken;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      start = 1;
      req_data.mode       = mode;
      req_data.elem_index = IDX_W'(idx);
      req_data.elem_value = val[VAL_W-1:0];
      req_data.step_count = CNT_W'(cnt);
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      propagate_item(req_data);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start = 0;
      while (expected_results.size() != 0 || busy) @(negedge clock);
   endtask

   // Register write, only with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input longint val);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = val[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we = 0;
      case (idx)
         CSR_TIME_STEP:   dt_reg    = val & 64'hFFFF;
         CSR_X_LOW:       x_lo      = longint'(signed'(val[23:0]));
         CSR_X_HIGH:      x_hi      = longint'(signed'(val[23:0]));
         CSR_Y_LOW:       y_lo      = longint'(signed'(val[23:0]));
         CSR_Y_HIGH:      y_hi      = longint'(signed'(val[23:0]));
         CSR_JOINT_LIMIT: joint_lim = val & 64'h7FFFFF;
         default: ;
      endcase
   endtask

   task automatic set_limits(input longint dt, input longint xl, input longint xh,
                             input longint yl, input longint yh, input longint jl);
      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      write_reg(CSR_TIME_STEP, dt);
      write_reg(CSR_X_LOW, xl);
      write_reg(CSR_X_HIGH, xh);
      write_reg(CSR_Y_LOW, yl);
      write_reg(CSR_Y_HIGH, yh);
      write_reg(CSR_JOINT_LIMIT, jl);
   endtask

   function automatic longint rand_range(input longint lo, input longint hi);
      return lo + longint'($urandom_range(0, hi - lo));
   endfunction

   function automatic longint rand_full();
      return longint'(signed'($urandom_range(0, 24'hFFFFFF) & 24'hFFFFFF));
   endfunction

   // Sane element value for a well-formed load
   function automatic longint sane_state(input int idx);
      if (idx < 2) return rand_range(-50 * 65536, 50 * 65536);
      if (idx == 2) return rand_range(-205887, 205887);
      return rand_range(-40 * 65536, 40 * 65536);
   endfunction

   function automatic longint sane_ctrl(input int idx);
      if (idx == 1) return rand_range(-600 * 65536, 600 * 65536);
      return rand_range(-300 * 65536, 300 * 65536);
   endfunction

   // Directed: every element written, field extremes, special step counts
   task automatic test_directed();
      no_idle = 1;
      send_item(MODE_LOAD_STATE, 0, 64'sd8388607, 0);
      send_item(MODE_LOAD_STATE, 1, -64'sd8388608, 8'hFF);
      for (int k = 2; k < N_STATE; k++) send_item(MODE_LOAD_STATE, k, sane_state(k), 0);
      for (int k = 0; k < N_CTRL; k++) send_item(MODE_LOAD_CTRL, k, sane_ctrl(k), 0);
      // out of bounds from the first step, clamped count
      send_item(MODE_RUN, 0, 0, 255);
      send_item(MODE_LOAD_STATE, 0, 0, 0);
      send_item(MODE_LOAD_STATE, 1, 0, 0);
      no_idle = 0;
      send_item(MODE_RUN, 0, 0, 0);
      send_item(MODE_RUN, 0, 0, 1);
      // ignored items: unused mode and indexes past each vector, then a clamped run
      send_item(MODE_UNUSED, 0, -64'sd8388608, 8'hFF);
      send_item(MODE_LOAD_STATE, 15, 64'sd8388607, 0);
      send_item(MODE_LOAD_CTRL, 15, -64'sd8388608, 0);
      send_item(MODE_RUN, 15, 0, 129);
   endtask

   // Register settings at their extremes
   task automatic test_register_extremes();
      set_limits(0, -5898240, 6553600, -6553600, 5898240, 3932160);
      send_item(MODE_RUN, 0, 0, 5);
      set_limits(65535, -8388608, 8388607, -8388608, 8388607, 8388607);
      send_item(MODE_RUN, 0, 0, 128);
      // empty bounds break on the first step
      set_limits(1, 1000, -1000, 5898240, -6553600, 0);
      send_item(MODE_RUN, 0, 0, 10);
      set_limits(655, -5898240, 6553600, -6553600, 5898240, 3932160);
   endtask

   // Random sequences: mostly loads then a run, some noise
   task automatic test_random();
      int left, nload, idx, cnt;
      left = RANDOM_ITEMS;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
         if ($urandom_range(0, 29) == 0) wait_drained();
         if ($urandom_range(0, 59) == 0)
            set_limits($urandom_range(1, 65535), rand_range(-100 * 65536, 0),
                       rand_range(0, 127 * 65536), rand_range(-127 * 65536, 0),
                       rand_range(0, 100 * 65536), rand_range(0, 8388607));
         if ($urandom_range(0, 4) != 0) begin
            nload = $urandom_range(1, 5);
            for (int i = 0; i < nload; i++) begin
               if ($urandom_range(0, 1)) begin
                  idx = $urandom_range(0, N_STATE - 1);
                  send_item(MODE_LOAD_STATE, idx, sane_state(idx), $urandom_range(0, 255));
               end else begin
                  idx = $urandom_range(0, N_CTRL - 1);
                  send_item(MODE_LOAD_CTRL, idx, sane_ctrl(idx), $urandom_range(0, 255));
               end
            end
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 255)
                                              : $urandom_range(1, 20);
            send_item(MODE_RUN, $urandom_range(0, 15), rand_full(), cnt);
            left -= nload + 1;
         end else begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, 16);
            send_item(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 15), rand_full(),
                      cnt);
            left--;
         end
      end
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      dt_reg = 655;
      x_lo = -5898240;
      x_hi = 6553600;
      y_lo = -6553600;
      y_hi = 5898240;
      joint_lim = 3932160;
      for (int k = 0; k < N_STATE; k++) pose_mirror[k] = 0;
      for (int k = 0; k < N_CTRL; k++) ctrl_mirror[k] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_directed();
      test_register_extremes();
      test_random();

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d transfers sent, %0d runs, %0d stopped on a bound, %0d results checked",
               items_sent, runs_sent, early_stops, results_seen);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d errors, %0d results missing", error_count, expected_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
